>>> hw/rtl/lad_pkg.sv
// ----------------------------------------------------------------------------
// lad_pkg
// Shared types and constants of the linear array deque.
// ----------------------------------------------------------------------------
package lad_pkg;

  localparam int VALUE_W = 32;
  localparam int OCC_W   = 5;
  localparam int CAP_W   = 5;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_REAR  = 2'd0,
    REQ_POP_REAR   = 2'd1,
    REQ_PUSH_FRONT = 2'd2,
    REQ_POP_FRONT  = 2'd3
  } req_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOFRONT = 2'd3
  } status_e_t;

  typedef struct packed {
    status_e_t        status;
    logic [OCC_W-1:0] occupancy;
    logic             pop_ok;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

>>> hw/rtl/linear_array_deque_top.sv
// ----------------------------------------------------------------------------
// linear_array_deque_top
// Double-ended queue over a linear slot store with a registered-read memory.
//
//   channel  ports                                        direction
//   in       in_valid, in_stall, in_req_type, in_push_value  word in
//   out      out_valid, out_stall, out_pop_value,
//            out_status, out_occupancy                     word out
//   cfg      cfg_we, cfg_wdata                             capacity write
//
// One word is accepted per cycle while in_stall is low; its result is held
// in the pending stage beside the registered slot memory read, then in the
// output register. Reset clears both indices and sets the capacity to 16.
// The slot memory has no reset. A stalled result holds the pending word,
// and input is stalled only while both the pending stage and output are full.
// ----------------------------------------------------------------------------
module linear_array_deque_top
  import lad_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic signed [VALUE_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VALUE_W-1:0] out_pop_value,
  output logic [STAT_W-1:0]        out_status,
  output logic [OCC_W-1:0]         out_occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mem_cmd_t              mem_cmd;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata_r;
  logic [VALUE_W-1:0]    rd_ext;
  result_t               res;
  result_t               pend_res_r;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_value_r;
  status_e_t             out_status_r;
  logic [OCC_W-1:0]      out_occ_r;
  logic                  acc, move;

  assign move     = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r && !move;
  assign acc      = in_valid && !in_stall;

  lad_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .acc        (acc),
    .req_type   (in_req_type),
    .push_value (in_push_value),
    .mem_cmd    (mem_cmd),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .res        (res)
  );

  lad_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .cmd     (mem_cmd),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata_r (mem_rdata_r)
  );

  generate
    if (DATA_WIDTH >= VALUE_W) begin : g_trunc
      assign rd_ext = mem_rdata_r[VALUE_W-1:0];
    end else begin : g_sext
      assign rd_ext = {{(VALUE_W-DATA_WIDTH){mem_rdata_r[DATA_WIDTH-1]}}, mem_rdata_r};
    end
  endgenerate

  always_comb begin
    pend_nxt      = acc ? 1'b1 : (move ? 1'b0 : pend_r);
    out_valid_nxt = move ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_res_r <= res;
    end
    if (move) begin
      out_value_r  <= pend_res_r.pop_ok ? rd_ext : '1;
      out_status_r <= pend_res_r.status;
      out_occ_r    <= pend_res_r.occupancy;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  a_stall_needs_pending : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> pend_r && out_valid_r)
    else $error("input stalled without a blocked pending word");

  a_pending_moves : assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !out_valid_r |=> out_valid_r)
    else $error("pending word did not reach an empty output register");

  a_failed_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_pop_value == '1)
    else $error("failed access returned a value other than minus one");

  a_one_mem_access : assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_cmd.wr_en && mem_cmd.rd_en))
    else $error("memory read and write issued together");

endmodule

>>> hw/rtl/lad_mem.sv
// ----------------------------------------------------------------------------
// lad_mem
// Slot store: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module lad_mem
  import lad_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4
) (
  input  logic                  clk,
  input  mem_cmd_t              cmd,
  input  logic [AW-1:0]         addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata_r
);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem_r[addr];
    end
  end

endmodule

>>> hw/rtl/lad_ctrl.sv
// ----------------------------------------------------------------------------
// lad_ctrl
// Capacity register, front and rear indices, and the per-word decision.
// ----------------------------------------------------------------------------
module lad_ctrl
  import lad_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_wdata,
  input  logic                  acc,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [VALUE_W-1:0]    push_value,
  output mem_cmd_t              mem_cmd,
  output logic [AW-1:0]         mem_addr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output result_t               res
);

  localparam int IDX_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (IDX_W > CAP_W) ? IDX_W : CAP_W;

  logic [CAP_W-1:0] capacity_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] rear_r, rear_nxt;
  logic [CMP_W-1:0] cap_ext, rear_ext, front_ext, depth_ext, occ_ext;
  logic [IDX_W-1:0] addr_full;
  logic             wr, rd;
  status_e_t        status;

  assign depth_ext = CMP_W'(DEPTH);
  assign rear_ext  = CMP_W'(rear_r);
  assign front_ext = CMP_W'(front_r);
  assign cap_ext   = (CMP_W'(capacity_r) > depth_ext) ? depth_ext : CMP_W'(capacity_r);

  always_comb begin
    status    = ST_OK;
    wr        = 1'b0;
    rd        = 1'b0;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    addr_full = rear_r;
    unique case (req_e_t'(req_type))
      REQ_PUSH_REAR: begin
        addr_full = rear_r;
        if (rear_ext >= cap_ext) begin
          status = ST_FULL;
        end else begin
          wr       = 1'b1;
          rear_nxt = rear_r + IDX_W'(1);
        end
      end
      REQ_POP_REAR: begin
        addr_full = rear_r - IDX_W'(1);
        if (rear_r <= front_r) begin
          status = ST_EMPTY;
        end else begin
          rd       = 1'b1;
          rear_nxt = rear_r - IDX_W'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        addr_full = front_r - IDX_W'(1);
        if (front_r == '0) begin
          status = ST_NOFRONT;
        end else begin
          wr        = 1'b1;
          front_nxt = front_r - IDX_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        addr_full = front_r;
        if (rear_r <= front_r || front_ext >= depth_ext) begin
          status = ST_EMPTY;
        end else begin
          rd        = 1'b1;
          front_nxt = front_r + IDX_W'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign occ_ext = CMP_W'(rear_nxt) - CMP_W'(front_nxt);

  assign mem_cmd.wr_en = acc && wr;
  assign mem_cmd.rd_en = acc && rd;
  assign mem_addr      = addr_full[AW-1:0];

  generate
    if (DATA_WIDTH <= VALUE_W) begin : g_narrow
      assign mem_wdata = push_value[DATA_WIDTH-1:0];
    end else begin : g_wide
      assign mem_wdata = {{(DATA_WIDTH-VALUE_W){1'b0}}, push_value};
    end
  endgenerate

  assign res.status    = status;
  assign res.occupancy = occ_ext[OCC_W-1:0];
  assign res.pop_ok    = rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      front_r    <= '0;
      rear_r     <= '0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (acc) begin
        front_r <= front_nxt;
        rear_r  <= rear_nxt;
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the linear array deque.
//
// A behavioral copy of the deque state predicts status, popped value and
// occupancy for every accepted word. The results are checked in order
// against that prediction. Directed tests cover empty access, value
// extremes and the capacity corner cases. Random traffic then runs under
// several capacity settings with varying idle and stall pressure.
// ----------------------------------------------------------------------------
module tb_top
  import lad_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_DEPTH   = 16;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct {
    logic [VALUE_W-1:0] pop_value;
    status_e_t          status;
    logic [OCC_W-1:0]   occupancy;
  } access_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CAP_W-1:0]          cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [REQ_W-1:0]          in_req_type = '0;
  logic signed [VALUE_W-1:0] in_push_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_pop_value;
  logic [STAT_W-1:0]         out_status;
  logic [OCC_W-1:0]          out_occupancy;

  logic [CAP_W-1:0]   capacity_reg;
  int unsigned        front_pos;
  int unsigned        rear_pos;
  logic [VALUE_W-1:0] slot_mem [SLOT_DEPTH];

  access_result_t pending_results [$];

  int send_idle_pct  = 13;
  int recv_stall_pct = 73;
  int fail_count     = 0;
  int checked_count  = 0;
  int cap_writes     = 0;
  int cycle_count    = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  linear_array_deque_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic access_result_t apply_access(req_e_t req, logic [VALUE_W-1:0] val);
    access_result_t r;
    int unsigned    lim;
    r.pop_value = '1;
    r.status    = ST_OK;
    lim = (capacity_reg > SLOT_DEPTH) ? SLOT_DEPTH : capacity_reg;
    case (req)
      REQ_PUSH_REAR: begin
        if (rear_pos >= lim || rear_pos >= SLOT_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_mem[rear_pos] = val;
          rear_pos++;
        end
      end
      REQ_POP_REAR: begin
        if (rear_pos <= front_pos || rear_pos == 0) begin
          r.status = ST_EMPTY;
        end else begin
          rear_pos--;
          r.pop_value = slot_mem[rear_pos];
        end
      end
      REQ_PUSH_FRONT: begin
        if (front_pos == 0) begin
          r.status = ST_NOFRONT;
        end else begin
          front_pos--;
          slot_mem[front_pos] = val;
        end
      end
      default: begin
        if (rear_pos <= front_pos || front_pos >= SLOT_DEPTH) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_value = slot_mem[front_pos];
          front_pos++;
        end
      end
    endcase
    r.occupancy = OCC_W'((rear_pos >= front_pos) ? rear_pos - front_pos : 0);
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no access outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        status_seen[want.status]++;
        if (out_pop_value !== want.pop_value) begin
          $error("pop_value: expected %0d, actual %0d",
                 $signed(want.pop_value), out_pop_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          fail_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, out_occupancy);
          fail_count++;
        end
      end
    end
  end

  task automatic send_word(req_e_t req, logic [VALUE_W-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_access(req, val));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_reg = cap;
    cap_writes++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_e_t pick_req(int mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      1:       return (roll < 70) ? REQ_PUSH_REAR : req_e_t'($urandom_range(3));
      2:       return (roll < 35) ? REQ_POP_REAR :
                      (roll < 70) ? REQ_POP_FRONT : req_e_t'($urandom_range(3));
      3:       return (roll < 35) ? REQ_PUSH_FRONT :
                      (roll < 70) ? REQ_POP_FRONT : req_e_t'($urandom_range(3));
      default: return req_e_t'($urandom_range(3));
    endcase
  endfunction

  task automatic test_empty_deque();
    write_capacity(CAP_RESET);
    send_word(REQ_POP_REAR, 32'h0000_0001);
    send_word(REQ_POP_FRONT, 32'hFFFF_FFFF);
    send_word(REQ_PUSH_FRONT, 32'h1357_9BDF);
  endtask

  task automatic test_value_extremes();
    send_word(REQ_PUSH_REAR, 32'h7FFF_FFFF);
    send_word(REQ_PUSH_REAR, 32'h8000_0000);
    send_word(REQ_PUSH_REAR, 32'hFFFF_FFFF);
    send_word(REQ_PUSH_REAR, 32'h0000_0000);
    send_word(REQ_POP_FRONT, 32'h0);
    send_word(REQ_POP_FRONT, 32'h0);
    send_word(REQ_PUSH_FRONT, 32'hA5A5_5A5A);
    send_word(REQ_POP_REAR, 32'h0);
    send_word(REQ_POP_REAR, 32'h0);
    send_word(REQ_POP_REAR, 32'h0);
    send_word(REQ_POP_FRONT, 32'h0);
  endtask

  task automatic test_zero_capacity();
    write_capacity(5'd0);
    send_word(REQ_PUSH_REAR, 32'h0000_00FF);
    send_word(REQ_PUSH_REAR, 32'hFFFF_FF00);
    send_word(REQ_POP_FRONT, 32'h0);
  endtask

  task automatic test_lowered_capacity();
    write_capacity(CAP_RESET);
    send_word(REQ_PUSH_REAR, 32'h1111_1111);
    send_word(REQ_PUSH_REAR, 32'h2222_2222);
    send_word(REQ_PUSH_REAR, 32'h3333_3333);
    write_capacity(5'd2);
    send_word(REQ_PUSH_REAR, 32'h4444_4444);
    send_word(REQ_POP_REAR, 32'h0);
    send_word(REQ_POP_FRONT, 32'h0);
  endtask

  task automatic test_capacity_above_depth();
    write_capacity(5'd31);
    send_word(REQ_PUSH_REAR, 32'hDEAD_0001);
    send_word(REQ_PUSH_REAR, 32'h0BAD_0002);
    send_word(REQ_POP_REAR, 32'h0);
  endtask

  task automatic test_random_traffic(int snd_pct, int rcv_pct, int count);
    logic [CAP_W-1:0] cap_list [8] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd7, 5'd24, 5'd12, 5'd16};
    int mode;
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    mode = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 62 == 0) write_capacity(cap_list[$urandom_range(7)]);
      if (i % 20 == 0) mode = $urandom_range(3);
      send_word(pick_req(mode), pick_value());
    end
  endtask

  initial begin
    capacity_reg = CAP_RESET;
    front_pos    = 0;
    rear_pos     = 0;
    foreach (slot_mem[i]) slot_mem[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_deque();
    test_value_extremes();
    test_zero_capacity();
    test_lowered_capacity();
    test_capacity_above_depth();
    test_random_traffic(13, 73, 175);
    test_random_traffic(73, 13, 175);
    test_random_traffic(0, 0, 175);

    drain_results();
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      fail_count++;
    end
    $display("Checked %0d result words across %0d capacity writes.", checked_count, cap_writes);
    $display("Status mix: ok %0d, full %0d, empty %0d, no front slot %0d.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOFRONT]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lad_pkg.sv
hw/rtl/lad_mem.sv
hw/rtl/lad_ctrl.sv
hw/rtl/linear_array_deque_top.sv
tb/tb_top.sv
